FILE: design/multimeter_reading_scaler_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multimeter reading scaler
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTIMETER_READING_SCALER_CORE_DEFINES_SVH
`define MULTIMETER_READING_SCALER_CORE_DEFINES_SVH

// cons must hold whenever ante holds
`define MRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold whenever a result item is offered
`define MRS_ASSERT_OUT(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) out_tvalid |-> (cons)) \
    else $error(msg);

`endif

FILE: design/mrs_pkg.sv
// ----------------------------------------------------------------------------
// mrs_pkg
// Types, widths and constants of the multimeter reading scaler.
// ----------------------------------------------------------------------------
package mrs_pkg;

  localparam int RC_W   = 12;   // ADC code width
  localparam int PIN_W  = 6;
  localparam int REF_W  = 21;   // reference in uV
  localparam int R1_W   = 24;   // parallel resistance in ohms
  localparam int MAG_W  = 34;   // |Vin| * reference_code
  localparam int SNUM_W = 36;   // supply numerator
  localparam int MAGK_W = 39;   // scaled voltage numerator
  localparam int NUM_W  = 86;   // resistance numerator
  localparam int DEN_W  = 60;   // main divisor
  localparam int QM_W   = 47;   // main quotient bits before saturation
  localparam int QS_W   = 35;   // supply quotient bits before saturation
  localparam int RD_W   = 48;   // reading
  localparam int SUP_W  = 35;   // supply

  localparam int DIV_STEPS = 2; // divider bits per pipeline stage

  localparam logic [32:0] VIN_OFFSET_UV = 33'd2000000;
  localparam logic [33:0] FULL_SCALE_UV = 34'd2500000;
  localparam logic [RD_W-1:0] POS_CAP = {1'b0, {(RD_W-1){1'b1}}};
  localparam logic [RD_W-1:0] NEG_MAG = {1'b1, {(RD_W-1){1'b0}}};
  localparam logic [SUP_W-1:0] SUP_CAP = {SUP_W{1'b1}};

  localparam logic CFG_REF_UV  = 1'b0;
  localparam logic CFG_PAR_OHM = 1'b1;

  typedef enum logic [2:0] {
    RNG_2V   = 3'd0,
    RNG_10V  = 3'd1,
    RNG_50V  = 3'd2,
    RNG_1K   = 3'd3,
    RNG_10K  = 3'd4,
    RNG_100K = 3'd5,
    RNG_1M   = 3'd6
  } range_t;

  typedef struct packed {
    logic [PIN_W-1:0] pins;
    logic [RC_W-1:0]  sc;
    logic [RC_W-1:0]  mc;
    logic [RC_W-1:0]  rc;
  } meas_t;

  typedef struct packed {
    range_t            rng;
    logic              neg;
    logic              err;
    logic              zero_rc;
    logic              sat_m;
    logic              sat_s;
    logic [DEN_W-1:0]  dm;
    logic [DEN_W-1:0]  rem_m;
    logic [QM_W-1:0]   nlo_m;
    logic [RC_W-1:0]   ds;
    logic [RC_W-1:0]   rem_s;
    logic [QS_W-1:0]   nlo_s;
  } div_item_t;

  typedef struct packed {
    logic             err;
    range_t           rng;
    logic [SUP_W-1:0] supply;
    logic [RD_W-1:0]  reading;
  } out_item_t;

endpackage

FILE: design/multimeter_reading_scaler_core.sv
// ----------------------------------------------------------------------------
// multimeter_reading_scaler_core
// Converts one set of ADC codes and range pins to a reading and supply voltage.
// ----------------------------------------------------------------------------
//   channel | dir | tdata (low bit up)                  | tuser
//   in_     | in  | reference, meter, supply codes      | range pins
//   out_    | out | reading (signed), supply microvolts | range used, error flag
//   cfg_    | in  | write enable, index, data           | -
//
// One item per cycle while the output is not stalled. Items pass through the front
// stages, the restoring divider at DIV_STEPS_PER_STAGE bits per stage, and the back stages.
// rst_n is synchronous; it clears every valid bit and loads both registers' defaults.
// A stalled output holds its item; empty stages upstream keep filling.
// ----------------------------------------------------------------------------
`include "multimeter_reading_scaler_core_defines.svh"

module multimeter_reading_scaler_core
  import mrs_pkg::*;
#(
  parameter int DIV_STEPS_PER_STAGE = DIV_STEPS
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [23:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // reference_code, meter_code, supply_code
  input  logic [5:0]  in_tuser,   // range_pins
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // reading, supply_microvolts
  output logic [3:0]  out_tuser   // range_used, error_flag
);

  logic [REF_W-1:0] ref_uv_r, ref_uv_nxt;
  logic [R1_W-1:0]  par_ohm_r, par_ohm_nxt;

  always_comb begin
    ref_uv_nxt  = ref_uv_r;
    par_ohm_nxt = par_ohm_r;
    if (cfg_we) begin
      case (cfg_addr)
        CFG_REF_UV:  ref_uv_nxt  = cfg_wdata[REF_W-1:0];
        CFG_PAR_OHM: par_ohm_nxt = cfg_wdata[R1_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_uv_r  <= REF_W'(1205000);
      par_ohm_r <= R1_W'(2000000);
    end else begin
      ref_uv_r  <= ref_uv_nxt;
      par_ohm_r <= par_ohm_nxt;
    end
  end

  meas_t     meas;
  logic      fr_valid, fr_ready;
  div_item_t fr_item;
  logic      dv_valid, dv_ready;
  div_item_t dv_item;
  out_item_t res;

  assign meas.rc   = in_tdata[11:0];
  assign meas.mc   = in_tdata[23:12];
  assign meas.sc   = in_tdata[35:24];
  assign meas.pins = in_tuser;

  mrs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .ref_uv    (ref_uv_r),
    .par_ohm   (par_ohm_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (meas),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_item  (fr_item)
  );

  mrs_div #(
    .STEPS (DIV_STEPS_PER_STAGE)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_item   (fr_item),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .out_item  (dv_item)
  );

  mrs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dv_valid),
    .in_ready  (dv_ready),
    .in_item   (dv_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (res)
  );

  assign out_tdata = {5'd0, res.supply, res.reading};
  assign out_tuser = {res.err, res.rng};

  `MRS_ASSERT_NOW(a_ready_when_drained, !out_tvalid, in_tready, "input stalled with output empty")
  `MRS_ASSERT_OUT(a_err_zero_reading, !out_tuser[3] || out_tdata[47:0] == 48'd0, "error with reading")
  `MRS_ASSERT_OUT(a_volt_bound, out_tuser[2:0] > RNG_50V || out_tdata[47:39] == 9'd0 || out_tdata[47:39] == 9'h1FF, "voltage reading out of bound")

endmodule

FILE: design/mrs_front.sv
// ----------------------------------------------------------------------------
// mrs_front
// Range decode, products and divisor/numerator setup in six stages.
// ----------------------------------------------------------------------------
module mrs_front
  import mrs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [REF_W-1:0] ref_uv,
  input  logic [R1_W-1:0]  par_ohm,
  input  logic             in_valid,
  output logic             in_ready,
  input  meas_t            in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output div_item_t        out_item
);

  localparam int NS = 6;

  typedef struct packed {
    range_t      rng;
    logic        zero_rc;
    logic [RC_W-1:0] rc;
    logic [32:0] mr;
    logic [32:0] b;
    logic [32:0] sr;
    logic [33:0] full;
    logic [17:0] r0;
    logic [51:0] p;
  } s0_t;

  typedef struct packed {
    range_t      rng;
    logic        zero_rc;
    logic [RC_W-1:0] rc;
    logic        neg;
    logic [MAG_W-1:0] mag;
    logic [SNUM_W-1:0] snum;
    logic [33:0] full;
    logic [17:0] r0;
    logic [51:0] p;
  } s1_t;

  typedef struct packed {
    range_t      rng;
    logic        zero_rc;
    logic [RC_W-1:0] rc;
    logic        neg;
    logic        verr;
    logic [MAGK_W-1:0] magk;
    logic [34:0] d;
    logic [59:0] mplo;
    logic [59:0] mphi;
    logic [51:0] mr0;
    logic [SNUM_W-1:0] snum;
  } s2_t;

  typedef struct packed {
    range_t      rng;
    logic        zero_rc;
    logic [RC_W-1:0] rc;
    logic        neg;
    logic        verr;
    logic [MAGK_W-1:0] magk;
    logic [58:0] r1d;
    logic [51:0] mr0;
    logic [NUM_W-1:0] nres;
    logic [SNUM_W-1:0] snum;
  } s3_t;

  typedef struct packed {
    range_t      rng;
    logic        zero_rc;
    logic [RC_W-1:0] rc;
    logic        neg;
    logic        err;
    logic [NUM_W-1:0] nm;
    logic [DEN_W-1:0] dm;
    logic [SNUM_W-1:0] snum;
  } s4_t;

  function automatic logic [17:0] base_ohms(range_t r);
    case (r)
      RNG_10K:  return 18'd2000;
      RNG_100K: return 18'd20000;
      RNG_1M:   return 18'd200000;
      default:  return 18'd200;
    endcase
  endfunction

  // base resistance times 1000, for the milliohm numerator
  function automatic logic [27:0] base_milliohms(range_t r);
    case (r)
      RNG_10K:  return 28'd2000000;
      RNG_100K: return 28'd20000000;
      RNG_1M:   return 28'd200000000;
      default:  return 28'd200000;
    endcase
  endfunction

  function automatic logic [4:0] volt_gain(range_t r);
    case (r)
      RNG_10V: return 5'd5;
      RNG_50V: return 5'd25;
      default: return 5'd1;
    endcase
  endfunction

  logic [NS-1:0] v_r;
  logic [NS:0]   adv;

  s0_t s0_r, s0_nxt;
  s1_t s1_r, s1_nxt;
  s2_t s2_r, s2_nxt;
  s3_t s3_r, s3_nxt;
  s4_t s4_r, s4_nxt;
  div_item_t s5_r, s5_nxt;

  always_comb begin
    adv[NS] = out_ready;
    for (int i = NS - 1; i >= 0; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[NS-1];
  assign out_item  = s5_r;

  // stage 0: range priority and first products
  always_comb begin
    if (in_item.pins[0])      s0_nxt.rng = RNG_50V;
    else if (in_item.pins[1]) s0_nxt.rng = RNG_10V;
    else if (in_item.pins[2]) s0_nxt.rng = RNG_2V;
    else if (in_item.pins[3]) s0_nxt.rng = RNG_10K;
    else if (in_item.pins[4]) s0_nxt.rng = RNG_100K;
    else if (in_item.pins[5]) s0_nxt.rng = RNG_1M;
    else                      s0_nxt.rng = RNG_1K;
    s0_nxt.zero_rc = (in_item.rc == '0);
    s0_nxt.rc      = in_item.rc;
    s0_nxt.mr      = 33'(in_item.mc) * 33'(ref_uv);
    s0_nxt.b       = 33'(in_item.rc) * VIN_OFFSET_UV;
    s0_nxt.sr      = 33'(in_item.sc) * 33'(ref_uv);
    s0_nxt.full    = 34'(in_item.rc) * FULL_SCALE_UV;
    s0_nxt.r0      = base_ohms(s0_nxt.rng);
    s0_nxt.p       = 52'(par_ohm) * 52'(base_milliohms(s0_nxt.rng));
  end

  // stage 1: signed input voltage as sign and magnitude
  always_comb begin
    logic [MAG_W-1:0] a;
    a = {s0_r.mr, 1'b0};
    s1_nxt.rng     = s0_r.rng;
    s1_nxt.zero_rc = s0_r.zero_rc;
    s1_nxt.rc      = s0_r.rc;
    s1_nxt.neg     = a < {1'b0, s0_r.b};
    s1_nxt.mag     = s1_nxt.neg ? ({1'b0, s0_r.b} - a) : (a - {1'b0, s0_r.b});
    s1_nxt.snum    = SNUM_W'(s0_r.sr) * SNUM_W'(6);
    s1_nxt.full    = s0_r.full;
    s1_nxt.r0      = s0_r.r0;
    s1_nxt.p       = s0_r.p;
  end

  // stage 2: scaled voltage, divider voltage, partial products
  always_comb begin
    s2_nxt.rng     = s1_r.rng;
    s2_nxt.zero_rc = s1_r.zero_rc;
    s2_nxt.rc      = s1_r.rc;
    s2_nxt.neg     = s1_r.neg;
    s2_nxt.verr    = !s1_r.neg && (s1_r.full <= s1_r.mag);
    s2_nxt.magk    = MAGK_W'(s1_r.mag) * MAGK_W'(volt_gain(s1_r.rng));
    s2_nxt.d       = s1_r.neg ? (35'(s1_r.full) + 35'(s1_r.mag))
                              : (35'(s1_r.full) - 35'(s1_r.mag));
    s2_nxt.mplo    = 60'(s1_r.mag) * 60'(s1_r.p[25:0]);
    s2_nxt.mphi    = 60'(s1_r.mag) * 60'(s1_r.p[51:26]);
    s2_nxt.mr0     = 52'(s1_r.mag) * 52'(s1_r.r0);
    s2_nxt.snum    = s1_r.snum;
  end

  // stage 3: parallel resistance term and full numerator
  always_comb begin
    s3_nxt.rng     = s2_r.rng;
    s3_nxt.zero_rc = s2_r.zero_rc;
    s3_nxt.rc      = s2_r.rc;
    s3_nxt.neg     = s2_r.neg;
    s3_nxt.verr    = s2_r.verr;
    s3_nxt.magk    = s2_r.magk;
    s3_nxt.r1d     = 59'(par_ohm) * 59'(s2_r.d);
    s3_nxt.mr0     = s2_r.mr0;
    s3_nxt.nres    = NUM_W'(s2_r.mplo) + (NUM_W'(s2_r.mphi) << 26);
    s3_nxt.snum    = s2_r.snum;
  end

  // stage 4: denominator, error, operand select
  always_comb begin
    logic is_res;
    logic ezero;
    logic [DEN_W-1:0] e;
    is_res = (s3_r.rng >= RNG_1K);
    ezero  = s3_r.neg ? (s3_r.r1d == '0 && s3_r.mr0 == '0)
                      : (s3_r.r1d <= 59'(s3_r.mr0));
    e      = s3_r.neg ? (DEN_W'(s3_r.r1d) + DEN_W'(s3_r.mr0))
                      : (DEN_W'(s3_r.r1d) - DEN_W'(s3_r.mr0));
    s4_nxt.rng     = s3_r.rng;
    s4_nxt.zero_rc = s3_r.zero_rc;
    s4_nxt.rc      = s3_r.rc;
    s4_nxt.neg     = s3_r.neg;
    s4_nxt.err     = s3_r.zero_rc || (is_res && (s3_r.verr || ezero));
    s4_nxt.nm      = is_res ? s3_r.nres : NUM_W'(s3_r.magk);
    s4_nxt.dm      = is_res ? e : DEN_W'(s3_r.rc);
    s4_nxt.snum    = s3_r.snum;
  end

  // stage 5: overflow check and divider seed
  always_comb begin
    s5_nxt.rng     = s4_r.rng;
    s5_nxt.neg     = s4_r.neg;
    s5_nxt.err     = s4_r.err;
    s5_nxt.zero_rc = s4_r.zero_rc;
    s5_nxt.sat_m   = DEN_W'(s4_r.nm[NUM_W-1:QM_W]) >= s4_r.dm;
    s5_nxt.sat_s   = RC_W'(s4_r.snum[SNUM_W-1]) >= s4_r.rc;
    s5_nxt.dm      = s4_r.dm;
    s5_nxt.rem_m   = DEN_W'(s4_r.nm[NUM_W-1:QM_W]);
    s5_nxt.nlo_m   = s4_r.nm[QM_W-1:0];
    s5_nxt.ds      = s4_r.rc;
    s5_nxt.rem_s   = RC_W'(s4_r.snum[SNUM_W-1]);
    s5_nxt.nlo_s   = s4_r.snum[QS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) s0_r <= s0_nxt;
    if (adv[1]) s1_r <= s1_nxt;
    if (adv[2]) s2_r <= s2_nxt;
    if (adv[3]) s3_r <= s3_nxt;
    if (adv[4]) s4_r <= s4_nxt;
    if (adv[5]) s5_r <= s5_nxt;
  end

endmodule

FILE: design/mrs_div.sv
// ----------------------------------------------------------------------------
// mrs_div
// Pipelined restoring divider, main and supply quotients side by side.
// ----------------------------------------------------------------------------
module mrs_div
  import mrs_pkg::*;
#(
  parameter int STEPS = DIV_STEPS
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  div_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output div_item_t out_item
);

  localparam int NST = (QM_W + STEPS - 1) / STEPS;

  // STEPS quotient bits; remainder and numerator share one shift register
  function automatic div_item_t div_stage(div_item_t x, int base);
    div_item_t y;
    logic [DEN_W:0] tm;
    logic [RC_W:0]  ts;
    y = x;
    for (int k = 0; k < STEPS; k++) begin
      if (base + k < QM_W) begin
        tm = {y.rem_m, y.nlo_m[QM_W-1]};
        if (tm >= {1'b0, y.dm}) begin
          tm      = tm - {1'b0, y.dm};
          y.nlo_m = {y.nlo_m[QM_W-2:0], 1'b1};
        end else begin
          y.nlo_m = {y.nlo_m[QM_W-2:0], 1'b0};
        end
        y.rem_m = tm[DEN_W-1:0];
      end
      if (base + k < QS_W) begin
        ts = {y.rem_s, y.nlo_s[QS_W-1]};
        if (ts >= {1'b0, y.ds}) begin
          ts      = ts - {1'b0, y.ds};
          y.nlo_s = {y.nlo_s[QS_W-2:0], 1'b1};
        end else begin
          y.nlo_s = {y.nlo_s[QS_W-2:0], 1'b0};
        end
        y.rem_s = ts[RC_W-1:0];
      end
    end
    return y;
  endfunction

  logic [NST-1:0] v_r;
  logic [NST:0]   adv;
  div_item_t      st_r   [NST];
  div_item_t      st_nxt [NST];

  always_comb begin
    adv[NST] = out_ready;
    for (int i = NST - 1; i >= 0; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[NST-1];
  assign out_item  = st_r[NST-1];

  for (genvar g = 0; g < NST; g++) begin : g_st
    if (g == 0) begin : g_first
      assign st_nxt[g] = div_stage(in_item, 0);
    end else begin : g_next
      assign st_nxt[g] = div_stage(st_r[g-1], g * STEPS);
    end

    always_ff @(posedge clk) begin
      if (adv[g]) st_r[g] <= st_nxt[g];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= in_valid;
      for (int i = 1; i < NST; i++) begin
        if (adv[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

endmodule

FILE: design/mrs_back.sv
// ----------------------------------------------------------------------------
// mrs_back
// Rounding, saturation and sign, ending in the output register.
// ----------------------------------------------------------------------------
module mrs_back
  import mrs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  div_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  typedef struct packed {
    range_t          rng;
    logic            neg;
    logic            err;
    logic            zero_rc;
    logic            sat_m;
    logic            sat_s;
    logic [QM_W:0]   qm;
    logic [QS_W:0]   qs;
  } rnd_t;

  logic [1:0] v_r;
  logic [2:0] adv;
  rnd_t       b0_r, b0_nxt;
  out_item_t  b1_r, b1_nxt;

  assign adv[2]    = out_ready;
  assign adv[1]    = !v_r[1] || adv[2];
  assign adv[0]    = !v_r[0] || adv[1];
  assign in_ready  = adv[0];
  assign out_valid = v_r[1];
  assign out_item  = b1_r;

  // round half up on the magnitude
  always_comb begin
    logic up_m;
    logic up_s;
    up_m = {in_item.rem_m, 1'b0} >= {1'b0, in_item.dm};
    up_s = {in_item.rem_s, 1'b0} >= {1'b0, in_item.ds};
    b0_nxt.rng     = in_item.rng;
    b0_nxt.neg     = in_item.neg;
    b0_nxt.err     = in_item.err;
    b0_nxt.zero_rc = in_item.zero_rc;
    b0_nxt.sat_m   = in_item.sat_m;
    b0_nxt.sat_s   = in_item.sat_s;
    b0_nxt.qm      = {1'b0, in_item.nlo_m} + (QM_W+1)'(up_m);
    b0_nxt.qs      = {1'b0, in_item.nlo_s} + (QS_W+1)'(up_s);
  end

  always_comb begin
    logic [RD_W-1:0] magn;
    magn = b0_r.sat_m ? NEG_MAG : RD_W'(b0_r.qm);
    b1_nxt.err = b0_r.err;
    b1_nxt.rng = b0_r.rng;
    if (b0_r.err) begin
      b1_nxt.reading = '0;
    end else if (b0_r.neg) begin
      b1_nxt.reading = -magn;
    end else begin
      b1_nxt.reading = (magn > POS_CAP) ? POS_CAP : magn;
    end
    if (b0_r.zero_rc) begin
      b1_nxt.supply = '0;
    end else if (b0_r.sat_s || b0_r.qs[QS_W]) begin
      b1_nxt.supply = SUP_CAP;
    end else begin
      b1_nxt.supply = b0_r.qs[QS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= in_valid;
      if (adv[1]) v_r[1] <= v_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) b0_r <= b0_nxt;
    if (adv[1]) b1_r <= b1_nxt;
  end

endmodule
